FILE: rtl/core/mtcp_pkg.sv
// Shared types and constants of the timer/counter/PWM block.
package mtcp_pkg;

  // Parameter defaults and limits
  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int COMPARE_UNITS_DEF = 2;
  localparam int MAX_UNITS         = 4;

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_PRESCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_OPTS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_A    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_B    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_A     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_B     = 3'd7;

  // Prescaler
  localparam int                PSC_W         = 10;
  localparam logic [3:0]        PRESCALE_STOP = 4'd0;
  localparam logic [3:0]        PRESCALE_DIV1 = 4'd1;
  localparam logic [3:0]        PRESCALE_MAX  = 4'd11;

  // Waveform modes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_CTC    = 3'd1;
  localparam logic [2:0] MODE_FAST   = 3'd2;
  localparam logic [2:0] MODE_PC     = 3'd3;
  localparam logic [2:0] MODE_PFC    = 3'd4;

  // Event option bits
  localparam int EVT_OVF_AT_TOP = 0;
  localparam int EVT_CAP_RISE   = 1;
  localparam int EVT_CAP_IS_TOP = 2;

  // Pin actions
  localparam logic [2:0] ACT_OFF         = 3'd0;
  localparam logic [2:0] ACT_TOGGLE      = 3'd1;
  localparam logic [2:0] ACT_CLEAR       = 3'd2;
  localparam logic [2:0] ACT_SET         = 3'd3;
  localparam logic [2:0] ACT_CLR_SET_BOT = 3'd4;
  localparam logic [2:0] ACT_SET_CLR_BOT = 3'd5;
  localparam logic [2:0] ACT_CLR_UP      = 3'd6;
  localparam logic [2:0] ACT_SET_UP      = 3'd7;

  typedef struct packed {
    logic       capture_pin;
    logic [1:0] pins_enabled;
    logic       power_off;
  } in_word_t;

  typedef struct packed {
    logic [15:0] counter_value;
    logic        count_down;
    logic        overflow_flag;
    logic        compare_a_flag;
    logic        compare_b_flag;
    logic        capture_flag;
    logic [15:0] capture_value;
    logic        pin_a;
    logic        pin_b;
  } out_word_t;

endpackage

FILE: rtl/core/mcu_timer_counter_pwm_top.sv
// Timer/counter with compare units, PWM waveform modes and input capture.
// Pipeline: a word is registered on input, then its result is registered; the
//   result moves in whenever the result register is free or draining.
// Throughput: one word (one system tick) per cycle unless out_ready stalls, set by
//   single pass of counter/compare logic between input stage and result register.
// Reset (rst_n low, synchronous): counter, prescaler, flags, pins and config clear;
//   top_value resets to all ones.
module mcu_timer_counter_pwm_top #(
  parameter int COUNTER_WIDTH = mtcp_pkg::COUNTER_WIDTH_DEF,
  parameter int COMPARE_UNITS = mtcp_pkg::COMPARE_UNITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mtcp_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mtcp_pkg::out_word_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [mtcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mtcp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW = COUNTER_WIDTH;
  localparam int NU = COMPARE_UNITS;
  localparam int MU = mtcp_pkg::MAX_UNITS;

  // ---------------- configuration registers ----------------
  logic [3:0]    rp_r;
  logic [2:0]    mode_r;
  logic [15:0]   top_r;
  logic [2:0]    evt_r;
  logic [15:0]   cmpa_r, cmpb_r;
  logic [2:0]    acta_r, actb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r   <= '0;
      mode_r <= mtcp_pkg::MODE_NORMAL;
      top_r  <= '1;
      evt_r  <= '0;
      cmpa_r <= '0;
      cmpb_r <= '0;
      acta_r <= mtcp_pkg::ACT_OFF;
      actb_r <= mtcp_pkg::ACT_OFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mtcp_pkg::REG_RUN_PRESCALE: rp_r   <= cfg_wdata[3:0];
        mtcp_pkg::REG_MODE:         mode_r <= cfg_wdata[2:0];
        mtcp_pkg::REG_TOP:          top_r  <= cfg_wdata;
        mtcp_pkg::REG_EVENT_OPTS:   evt_r  <= cfg_wdata[2:0];
        mtcp_pkg::REG_COMPARE_A:    cmpa_r <= cfg_wdata;
        mtcp_pkg::REG_COMPARE_B:    cmpb_r <= cfg_wdata;
        mtcp_pkg::REG_ACTION_A:     acta_r <= cfg_wdata[2:0];
        mtcp_pkg::REG_ACTION_B:     actb_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake: input stage and result register ----------------
  logic                s1_valid_r;
  mtcp_pkg::in_word_t  s1_data_r;
  logic                out_valid_r;
  mtcp_pkg::out_word_t out_data_r;
  logic                adv;

  // Stage 1 moves into the result register when that register is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // ---------------- timer state ----------------
  logic [CW-1:0]                  count_r, count_nxt;
  logic                           dir_r, dir_nxt;
  logic [mtcp_pkg::PSC_W-1:0]     psc_r, psc_nxt;
  logic [NU-1:0]                  pend_r, pend_nxt;
  logic                           prev_cap_r;
  logic [CW-1:0]                  capt_r, capt_nxt;
  logic [NU-1:0]                  pin_r, pin_nxt;
  logic                           ovf_nxt, capf_nxt;
  logic [NU-1:0]                  raised;

  // pin action on a compare match
  function automatic logic pin_on_match(logic lvl, logic [2:0] act, logic dn, logic guard);
    logic res;
    res = lvl;
    if (!dn) begin
      case (act)
        mtcp_pkg::ACT_TOGGLE:      res = ~lvl;
        mtcp_pkg::ACT_CLEAR:       res = 1'b0;
        mtcp_pkg::ACT_CLR_SET_BOT: res = 1'b0;
        mtcp_pkg::ACT_SET:         res = 1'b1;
        mtcp_pkg::ACT_SET_CLR_BOT: res = 1'b1;
        mtcp_pkg::ACT_CLR_UP:      res = guard ? 1'b0 : lvl;
        mtcp_pkg::ACT_SET_UP:      res = guard ? 1'b1 : lvl;
        default:                   res = lvl;
      endcase
    end else begin
      case (act)
        mtcp_pkg::ACT_CLR_UP: res = guard ? 1'b1 : lvl;
        mtcp_pkg::ACT_SET_UP: res = guard ? 1'b0 : lvl;
        default:              res = lvl;
      endcase
    end
    return res;
  endfunction

  // pin action at bottom (up-counting only)
  function automatic logic pin_at_bottom(logic lvl, logic [2:0] act);
    logic res;
    case (act)
      mtcp_pkg::ACT_CLR_SET_BOT: res = 1'b1;
      mtcp_pkg::ACT_SET_CLR_BOT: res = 1'b0;
      default:                   res = lvl;
    endcase
    return res;
  endfunction

  // Per-unit compare values and actions; units past B have none
  logic [CW-1:0] ocr    [NU];
  logic [2:0]    act    [NU];
  logic [MU-1:0] en_vec;

  always_comb begin
    for (int i = 0; i < NU; i++) begin
      if (i == 0) begin
        ocr[i] = cmpa_r[CW-1:0];
        act[i] = acta_r;
      end else if (i == 1) begin
        ocr[i] = cmpb_r[CW-1:0];
        act[i] = actb_r;
      end else begin
        ocr[i] = '0;
        act[i] = mtcp_pkg::ACT_OFF;
      end
    end
  end

  assign en_vec = MU'(s1_data_r.pins_enabled);

  // Decoded controls
  logic                       stopped, bad_psc, bad_mode, dual, guard;
  logic [CW-1:0]              top;
  logic [CW:0]                count_p1;
  logic [mtcp_pkg::PSC_W-1:0] presc_m1;
  logic                       raise_now, tick, dir_eff, at_bottom, cap_edge;

  assign stopped  = s1_data_r.power_off || (rp_r == mtcp_pkg::PRESCALE_STOP);
  assign bad_psc  = rp_r > mtcp_pkg::PRESCALE_MAX;
  assign bad_mode = mode_r > mtcp_pkg::MODE_PFC;
  assign dual     = (mode_r == mtcp_pkg::MODE_PC) || (mode_r == mtcp_pkg::MODE_PFC);
  assign top      = (mode_r == mtcp_pkg::MODE_NORMAL) ? '1 : top_r[CW-1:0];
  assign count_p1 = {1'b0, count_r} + (CW+1)'(1);
  // divider minus one: 2^(n-1) - 1
  assign presc_m1 = mtcp_pkg::PSC_W'((11'd1 << (rp_r - 4'd1)) - 11'd1);
  assign raise_now = (rp_r == mtcp_pkg::PRESCALE_DIV1) ||
                     (psc_r == presc_m1 - mtcp_pkg::PSC_W'(1));
  assign tick     = !(psc_r < presc_m1);
  assign dir_eff  = dual ? dir_r : 1'b0;
  assign guard    = (count_p1 != {1'b0, top}) && (count_r != CW'(1));
  assign at_bottom = (!dual && count_r == top) ||
                     (dual && dir_eff && count_r == CW'(1));
  assign cap_edge = evt_r[mtcp_pkg::EVT_CAP_RISE] ? (!prev_cap_r && s1_data_r.capture_pin)
                                                  : (prev_cap_r && !s1_data_r.capture_pin);

  always_comb begin
    count_nxt = count_r;
    dir_nxt   = dir_r;
    psc_nxt   = psc_r;
    pend_nxt  = pend_r;
    capt_nxt  = capt_r;
    pin_nxt   = pin_r;
    ovf_nxt   = 1'b0;
    capf_nxt  = 1'b0;
    raised    = '0;
    if (stopped) begin
      psc_nxt  = '0;
      pend_nxt = '0;
    end else if (bad_psc) begin
      psc_nxt = '0;
    end else if (!bad_mode) begin
      dir_nxt = dir_eff;
      // pending compare flags go out just ahead of the timer clock
      if (raise_now) begin
        raised   = pend_r;
        pend_nxt = '0;
      end
      if (cap_edge) begin
        capf_nxt = 1'b1;
        if (!evt_r[mtcp_pkg::EVT_CAP_IS_TOP]) capt_nxt = count_r;
      end
      if (!tick) begin
        psc_nxt = psc_r + mtcp_pkg::PSC_W'(1);
      end else begin
        if (!dir_eff && count_p1 == {1'b0, top} && evt_r[mtcp_pkg::EVT_OVF_AT_TOP])
          ovf_nxt = 1'b1;
        for (int i = 0; i < NU; i++) begin
          if ((!dir_eff && count_p1 == {1'b0, ocr[i]}) ||
              (dir_eff && {1'b0, count_r} == {1'b0, ocr[i]} + (CW+1)'(1))) begin
            pend_nxt[i] = 1'b1;
            if (en_vec[i]) pin_nxt[i] = pin_on_match(pin_r[i], act[i], dir_eff, guard);
          end
        end
        if (at_bottom) begin
          if (!evt_r[mtcp_pkg::EVT_OVF_AT_TOP]) ovf_nxt = 1'b1;
          for (int i = 0; i < NU; i++) begin
            if (en_vec[i] && !dir_eff) pin_nxt[i] = pin_at_bottom(pin_nxt[i], act[i]);
          end
        end
        if (!dual && count_r == top) begin
          count_nxt = '0;
        end else if (dual && count_r == top) begin
          dir_nxt   = 1'b1;
          count_nxt = count_r - CW'(1);
        end else if (dual && count_r == '0) begin
          dir_nxt   = 1'b0;
          count_nxt = CW'(1);
        end else if (!dir_eff) begin
          count_nxt = count_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
        end
        psc_nxt = '0;
      end
    end
  end

  logic [MU-1:0] raised_ext, pin_ext;
  assign raised_ext = MU'(raised);
  assign pin_ext    = MU'(pin_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      dir_r      <= 1'b0;
      psc_r      <= '0;
      pend_r     <= '0;
      prev_cap_r <= 1'b0;
      capt_r     <= '0;
      pin_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        count_r    <= count_nxt;
        dir_r      <= dir_nxt;
        psc_r      <= psc_nxt;
        pend_r     <= pend_nxt;
        prev_cap_r <= s1_data_r.capture_pin;
        capt_r     <= capt_nxt;
        pin_r      <= pin_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.counter_value  <= 16'(count_nxt);
      out_data_r.count_down     <= dir_nxt;
      out_data_r.overflow_flag  <= ovf_nxt;
      out_data_r.compare_a_flag <= raised_ext[0];
      out_data_r.compare_b_flag <= raised_ext[1];
      out_data_r.capture_flag   <= capf_nxt;
      out_data_r.capture_value  <= 16'(capt_nxt);
      out_data_r.pin_a          <= pin_ext[0];
      out_data_r.pin_b          <= pin_ext[1];
    end
  end

`ifndef SYNTH
  // a stopped or powered-off tick drops every pending compare flag
  a_stop_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stopped) |=> (pend_r == '0))
    else $error("pending flags survive a stopped tick");

  // a stopped tick neither counts nor raises overflow
  a_stop_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && stopped) |=> (count_r == $past(count_r) && !out_data_r.overflow_flag))
    else $error("counter moved while stopped");

  // single-slope modes always count up once running
  a_single_slope_up: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !stopped && !bad_psc &&
     (mode_r == mtcp_pkg::MODE_NORMAL || mode_r == mtcp_pkg::MODE_CTC ||
      mode_r == mtcp_pkg::MODE_FAST)) |=> !dir_r)
    else $error("down count in single-slope mode");
`endif

endmodule
